// ===== hdl/sync_xor_frame_deframer_top_macros.svh =====
// Assertion macros for the sync/XOR frame deframer.
// Included by the top level, which has concurrent checks; no other dependencies.
`ifndef SYNC_XOR_FRAME_DEFRAMER_TOP_MACROS_SVH
`define SYNC_XOR_FRAME_DEFRAMER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Check under clock, disabled while reset is asserted.
`define SXFD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sxfd assertion failed");
// Check under clock, also active during reset.
`define SXFD_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("sxfd assertion failed");
`else
`define SXFD_ASSERT(name, clk, rst_n, prop)
`define SXFD_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ===== hdl/sxfd_pkg.sv =====
// Shared constants and types for the sync/XOR frame deframer.
// No dependencies; imported by the top level and the frame check.
`timescale 1ns / 1ps

package sxfd_pkg;

  localparam int unsigned FrameLen = 15;
  localparam int unsigned CheckPos = FrameLen - 1;
  localparam int unsigned CntW     = $clog2(FrameLen + 1);

  localparam logic [7:0] SyncFirstRst  = 8'h55;
  localparam logic [7:0] SyncSecondRst = 8'hAA;

  typedef enum logic [0:0] {
    CfgSyncFirst  = 1'b0,
    CfgSyncSecond = 1'b1
  } cfg_idx_e;

  typedef logic [FrameLen-1:0][7:0] window_t;

  typedef struct packed {
    logic sync_ok;
    logic sum_ok;
  } chk_status_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } words_t;

endpackage

// ===== hdl/sync_xor_frame_deframer_top.sv =====
// Top level of the sync/XOR frame deframer: cell chain, fill count, output register.
// Uses sxfd_pkg, sxfd_cell, sxfd_check and the assertion macro header.
//
//   channel  | direction | signals                          | accepted when
//   ---------+-----------+----------------------------------+----------------------------
//   config   | in        | cfg_we_i, cfg_idx_i, cfg_wdata_i  | cfg_we_i high
//   rx byte  | in        | in_valid_i/in_ready_o, rx_byte_i  | in_valid_i & in_ready_o
//   frame    | out       | out_valid_o/out_ready_i, x/y/z    | out_valid_o & out_ready_i
//
// One byte per cycle. A byte shifts through the 15-cell chain on the cycle it is taken;
// the frame check runs on that same beat and a good frame shows at the output next cycle.
// Reset clears fill count and output valid, presets sync registers; no clearing pass.
// The input stalls only when the next byte would close a window while a frame still
// waits at the output, so up to 14 bytes are taken under an output stall.
`timescale 1ns / 1ps
`include "sync_xor_frame_deframer_top_macros.svh"

module sync_xor_frame_deframer_top
  import sxfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] x_bits_o,
  output logic [31:0] y_bits_o,
  output logic [31:0] z_bits_o
);

  logic [7:0]      sync_first_q, sync_first_d;
  logic [7:0]      sync_second_q, sync_second_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  words_t          words_q, words_d;

  window_t     win, nxt;
  chk_status_t status;
  words_t      words;
  logic        in_acc, closing, frame_ok;

  // cell chain: oldest byte in cell 0, new byte enters at the tail
  for (genvar g = 0; g < FrameLen; g++) begin : g_cell
    if (g == FrameLen - 1) begin : g_tail
      assign nxt[g] = rx_byte_i;
    end else begin : g_body
      assign nxt[g] = win[g+1];
    end
    sxfd_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(in_acc),
      .byte_i (nxt[g]),
      .byte_o (win[g])
    );
  end

  sxfd_check u_check (
    .win_i        (nxt),
    .sync_first_i (sync_first_q),
    .sync_second_i(sync_second_q),
    .status_o     (status),
    .words_o      (words)
  );

  assign closing    = (cnt_q == CntW'(CheckPos));
  assign in_ready_o = !(closing && out_valid_q && !out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;
  assign frame_ok   = closing && status.sync_ok && status.sum_ok;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc) begin
      if (closing) begin
        cnt_d = frame_ok ? '0 : CntW'(CheckPos);
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    words_d     = words_q;
    if (in_acc && frame_ok) begin
      out_valid_d = 1'b1;
      words_d     = words;
    end
  end

  always_comb begin
    sync_first_d  = sync_first_q;
    sync_second_d = sync_second_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgSyncFirst:  sync_first_d  = cfg_wdata_i;
        CfgSyncSecond: sync_second_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
      sync_first_q  <= SyncFirstRst;
      sync_second_q <= SyncSecondRst;
    end else begin
      cnt_q         <= cnt_d;
      out_valid_q   <= out_valid_d;
      sync_first_q  <= sync_first_d;
      sync_second_q <= sync_second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    words_q <= words_d;
  end

  assign out_valid_o = out_valid_q;
  assign x_bits_o    = words_q.x;
  assign y_bits_o    = words_q.y;
  assign z_bits_o    = words_q.z;

  // count is unknown until reset is asserted
  `SXFD_ASSERT_ALWAYS(a_cnt_range, clk_i, !rst_ni || (cnt_q <= CntW'(CheckPos)))
  `SXFD_ASSERT(a_good_frame, clk_i, rst_ni, (in_acc && frame_ok) |=> (out_valid_q && cnt_q == '0))
  `SXFD_ASSERT(a_fill_step, clk_i, rst_ni, (in_acc && !closing) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
  `SXFD_ASSERT(a_bad_frame, clk_i, rst_ni, (in_acc && closing && !frame_ok) |=> (cnt_q == CntW'(CheckPos)))
  `SXFD_ASSERT(a_stall_cause, clk_i, rst_ni, !in_ready_o |-> (out_valid_q && closing))

endmodule

// ===== hdl/sxfd_cell.sv =====
// One byte cell of the sliding window shift line.
// Depends on nothing but the clock; chained by the top level.
`timescale 1ns / 1ps

module sxfd_cell (
  input  logic       clk_i,
  input  logic       shift_i,
  input  logic [7:0] byte_i,
  output logic [7:0] byte_o
);

  logic [7:0] byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (shift_i) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule

// ===== hdl/sxfd_check.sv =====
// Frame check: sync bytes, XOR checksum over the payload, word assembly.
// Uses sxfd_pkg; purely combinational.
`timescale 1ns / 1ps

module sxfd_check
  import sxfd_pkg::*;
(
  input  window_t     win_i,
  input  logic [7:0]  sync_first_i,
  input  logic [7:0]  sync_second_i,
  output chk_status_t status_o,
  output words_t      words_o
);

  localparam int unsigned NumPairs = (CheckPos - 2) / 2;

  logic [NumPairs-1:0][7:0] pair_x;
  logic [7:0]               sum;

  // first tree level: independent pairs of payload bytes
  always_comb begin
    for (int i = 0; i < NumPairs; i++) begin
      pair_x[i] = win_i[2 + 2*i] ^ win_i[3 + 2*i];
    end
  end

  assign sum = (pair_x[0] ^ pair_x[1]) ^ (pair_x[2] ^ pair_x[3]) ^ (pair_x[4] ^ pair_x[5]);

  assign status_o.sync_ok = (win_i[0] == sync_first_i) && (win_i[1] == sync_second_i);
  assign status_o.sum_ok  = (sum == win_i[CheckPos]);

  assign words_o.x = {win_i[5],  win_i[4],  win_i[3],  win_i[2]};
  assign words_o.y = {win_i[9],  win_i[8],  win_i[7],  win_i[6]};
  assign words_o.z = {win_i[13], win_i[12], win_i[11], win_i[10]};

endmodule
